[rtl/vag_pkg.sv]
// Shared types and constants of the voice activity gate.
// Register indexes, reset values, buffer action codes, controller/datapath
// command and status structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vag_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int PEAK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SPM_W      = 13;
    localparam int CLOCK_W    = 32;
    localparam int ACTION_W   = 2;

    // Default chunk length limit
    localparam int MAX_CHUNK_SAMPLES_DEF = 1024;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DETECT_ENABLE   = 3'd0,
        REG_LEVEL_THRESHOLD = 3'd1,
        REG_HEAD_MARGIN_MS  = 3'd2,
        REG_TAIL_MARGIN_MS  = 3'd3,
        REG_MIN_SAMPLE_MS   = 3'd4,
        REG_SAMPLES_PER_MS  = 3'd5,
        REG_MAX_AMPLITUDE   = 3'd6
    } t_reg_idx;

    // Register reset values
    localparam logic              RST_DETECT_ENABLE   = 1'b1;
    localparam logic [PEAK_W-1:0] RST_LEVEL_THRESHOLD = 16'd2000;
    localparam logic [PEAK_W-1:0] RST_HEAD_MARGIN_MS  = 16'd300;
    localparam logic [PEAK_W-1:0] RST_TAIL_MARGIN_MS  = 16'd300;
    localparam logic [PEAK_W-1:0] RST_MIN_SAMPLE_MS   = 16'd150;
    localparam logic [SPM_W-1:0]  RST_SAMPLES_PER_MS  = 13'd16;
    localparam logic [PEAK_W-1:0] RST_MAX_AMPLITUDE   = 16'd32767;

    // Buffer action codes for the external buffer manager
    typedef enum logic [ACTION_W-1:0] {
        ACT_HOLD    = 2'd0,
        ACT_TRIM    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_RAW     = 2'd3
    } t_action;

    // Controller -> datapath commands
    typedef struct packed {
        logic capture;
        logic accum;
        logic div_start;
        logic div_sel_clock;
        logic take_mean;
        logic advance;
        logic gate;
        logic emit;
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic last;
        logic div_done;
        logic detect_enable;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

[rtl/vag_if.sv]
// Valid/ready channel interfaces of the voice activity gate:
// sample input, chunk result output and configuration write.
// Depends on vag_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface vag_in_if import vag_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       chunk_end;

    modport source (output valid, output sample, output chunk_end, input ready);
    modport sink   (input valid, input sample, input chunk_end, output ready);
endinterface

interface vag_out_if import vag_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PEAK_W-1:0]   chunk_peak;
    logic [PEAK_W-1:0]   chunk_mean;
    logic                clipped;
    logic [PEAK_W-1:0]   highest_peak;
    logic [PEAK_W-1:0]   lowest_peak;
    logic [ACTION_W-1:0] buffer_action;
    logic                listening;
    logic                complete;

    modport source (output valid, output chunk_peak, output chunk_mean, output clipped,
                    output highest_peak, output lowest_peak, output buffer_action,
                    output listening, output complete, input ready);
    modport sink   (input valid, input chunk_peak, input chunk_mean, input clipped,
                    input highest_peak, input lowest_peak, input buffer_action,
                    input listening, input complete, output ready);
endinterface

interface vag_cfg_if import vag_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/vag_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the mean and
// millisecond clock computations. Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module vag_div #(
    parameter int DIVIDEND_W = 27,
    parameter int DIVISOR_W  = 13
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [DIVISOR_W-1:0]  i_divisor,
    output logic      [DIVIDEND_W-1:0] o_quotient,
    output logic                       o_done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIVISOR_W:0]    w_shift;
    logic [DIVISOR_W:0]    w_diff;
    logic                  w_fits;

    // Shift next dividend bit into the partial remainder and trial-subtract
    assign w_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign w_fits  = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    // Step counter and handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shifting
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DIVISOR_W-1:0] : w_shift[DIVISOR_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

`default_nettype wire

[rtl/vag_ctrl.sv]
// Sequencing state machine of the voice activity gate: accumulate, divide,
// advance the clock, run the gate, hand off the result. Depends on vag_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vag_ctrl import vag_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_CLK_GO,
        S_CLK_WAIT,
        S_GATE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.last ? S_MEAN_GO : S_IDLE;
            end
            S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.take_mean = 1'b1;
                    n_state         = i_status.detect_enable ? S_CLK_GO : S_GATE;
                end
            end
            S_CLK_GO: begin
                o_cmd.div_start     = 1'b1;
                o_cmd.div_sel_clock = 1'b1;
                n_state             = S_CLK_WAIT;
            end
            S_CLK_WAIT: begin
                o_cmd.div_sel_clock = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_GATE;
                end
            end
            S_GATE: begin
                o_cmd.gate = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[rtl/vag_dp.sv]
// Datapath of the voice activity gate: configuration registers, chunk
// accumulators, shared divider, peak statistics, gate state and the output
// register. Depends on vag_pkg, vag_if and vag_div.
`timescale 1ns / 1ps
`default_nettype none

module vag_dp import vag_pkg::*; #(
    parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_SAMPLES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_cmd                       i_cmd,
    output t_status                         o_status,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_chunk_end,
    vag_cfg_if.sink                         i_cfg,
    vag_out_if.source                       o_out
);

    localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int DVS_W = (CNT_W > SPM_W) ? CNT_W : SPM_W;

    // Configuration
    logic              r_detect_enable;
    logic [PEAK_W-1:0] r_level_threshold;
    logic [PEAK_W-1:0] r_tail_margin_ms;
    logic [PEAK_W-1:0] r_min_sample_ms;
    logic [SPM_W-1:0]  r_samples_per_ms;
    logic [PEAK_W-1:0] r_max_amplitude;

    // Captured word and chunk accumulators
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_chunk_end;
    logic [PEAK_W-1:0]   r_run_peak;
    logic [SUM_W-1:0]    r_run_sum;
    logic [CNT_W-1:0]    r_run_count;
    logic [PEAK_W-1:0]   w_mag;
    logic [CNT_W-1:0]    w_count_inc;

    // Divider
    logic [SUM_W-1:0] w_dividend;
    logic [DVS_W-1:0] w_divisor;
    logic [SUM_W-1:0] w_quo;
    logic             w_div_done;
    logic [SPM_W-1:0] w_spm;

    // Statistics, clock and gate
    logic [PEAK_W-1:0]  r_mean;
    logic [PEAK_W-1:0]  r_top_peak;
    logic [PEAK_W-1:0]  r_bottom_peak;
    logic [PEAK_W-1:0]  r_prev_level;
    logic [CLOCK_W-1:0] r_clock_ms;
    logic [CLOCK_W-1:0] r_time_below;
    logic [CLOCK_W-1:0] r_time_above;
    logic               r_await_start;
    logic               r_await_finish;
    logic               r_recording;
    logic               n_await_start;
    logic               n_await_finish;
    logic               n_recording;
    logic [CLOCK_W-1:0] n_time_below;
    logic [CLOCK_W-1:0] n_time_above;
    logic [CLOCK_W-1:0] w_since_below;
    logic [CLOCK_W-1:0] w_since_above;
    logic               w_pass;
    logic               w_trim;
    logic               w_listen;
    logic               w_done;
    t_action            w_action;
    logic               w_clip;

    // Gate results awaiting hand-off
    t_action r_res_action;
    logic    r_res_listen;
    logic    r_res_done;
    logic    r_res_clip;

    // Output register
    logic                r_out_valid;
    logic [PEAK_W-1:0]   r_out_peak;
    logic [PEAK_W-1:0]   r_out_mean;
    logic                r_out_clip;
    logic [PEAK_W-1:0]   r_out_high;
    logic [PEAK_W-1:0]   r_out_low;
    logic [ACTION_W-1:0] r_out_action;
    logic                r_out_listen;
    logic                r_out_done;

    // Configuration writes; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_enable   <= RST_DETECT_ENABLE;
            r_level_threshold <= RST_LEVEL_THRESHOLD;
            r_tail_margin_ms  <= RST_TAIL_MARGIN_MS;
            r_min_sample_ms   <= RST_MIN_SAMPLE_MS;
            r_samples_per_ms  <= RST_SAMPLES_PER_MS;
            r_max_amplitude   <= RST_MAX_AMPLITUDE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DETECT_ENABLE:   r_detect_enable   <= i_cfg.data[0];
                REG_LEVEL_THRESHOLD: r_level_threshold <= i_cfg.data;
                REG_HEAD_MARGIN_MS: begin
                    // head margin is applied by the external buffer manager
                end
                REG_TAIL_MARGIN_MS:  r_tail_margin_ms  <= i_cfg.data;
                REG_MIN_SAMPLE_MS:   r_min_sample_ms   <= i_cfg.data;
                REG_SAMPLES_PER_MS:  r_samples_per_ms  <= i_cfg.data[SPM_W-1:0];
                REG_MAX_AMPLITUDE:   r_max_amplitude   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample    <= i_sample;
            r_chunk_end <= i_chunk_end;
        end
    end

    // Magnitude; the most negative sample maps to 2^(SAMPLE_W-1)
    assign w_mag       = r_sample[SAMPLE_W-1] ? (~r_sample + 1'b1) : r_sample;
    assign w_count_inc = r_run_count + 1'b1;

    // Chunk accumulators, cleared when the result is handed off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_peak  <= '0;
            r_run_sum   <= '0;
            r_run_count <= '0;
        end else if (i_cmd.accum) begin
            if (w_mag > r_run_peak) begin
                r_run_peak <= w_mag;
            end
            r_run_sum   <= r_run_sum + SUM_W'(w_mag);
            r_run_count <= w_count_inc;
        end else if (i_cmd.emit) begin
            r_run_peak  <= '0;
            r_run_sum   <= '0;
            r_run_count <= '0;
        end
    end

    // Divider operands: sum / count for the mean, count / rate for the clock
    assign w_spm      = (r_samples_per_ms == '0) ? SPM_W'(1) : r_samples_per_ms;
    assign w_dividend = i_cmd.div_sel_clock ? SUM_W'(r_run_count) : r_run_sum;
    assign w_divisor  = i_cmd.div_sel_clock ? DVS_W'(w_spm) : DVS_W'(r_run_count);

    vag_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_mean) begin
            r_mean <= PEAK_W'(w_quo);
        end
    end

    // Elapsed times wrap with the 32-bit clock
    assign w_since_below = r_clock_ms - r_time_below;
    assign w_since_above = r_clock_ms - r_time_above;

    // Clip when peak + 1 reaches full scale (a zero full scale always clips)
    assign w_clip = ({1'b0, r_run_peak} + 1'b1) >= {1'b0, r_max_amplitude};

    // Threshold gate with minimum-length start and tail hangover
    always_comb begin
        n_await_start  = r_await_start;
        n_await_finish = r_await_finish;
        n_recording    = r_recording;
        n_time_below   = r_time_below;
        n_time_above   = r_time_above;
        w_pass         = 1'b0;
        w_trim         = 1'b0;
        w_listen       = 1'b0;
        w_done         = 1'b0;
        if (r_run_peak > r_level_threshold) begin
            if (r_prev_level > r_level_threshold) begin
                if (r_await_start) begin
                    if (w_since_below > CLOCK_W'(r_min_sample_ms)) begin
                        n_await_start  = 1'b0;
                        n_await_finish = 1'b1;
                        if (!r_recording) begin
                            w_listen    = 1'b1;
                            w_pass      = 1'b1;
                            n_recording = 1'b1;
                        end
                    end
                end else begin
                    w_pass = 1'b1;
                end
            end
            n_time_above = r_clock_ms;
        end else begin
            n_await_start = 1'b1;
            if (r_prev_level < r_level_threshold) begin
                if (r_await_finish) begin
                    w_pass = 1'b1;
                    if (w_since_above > CLOCK_W'(r_tail_margin_ms)) begin
                        n_recording    = 1'b0;
                        n_await_finish = 1'b0;
                        w_done         = 1'b1;
                    end
                end else begin
                    w_trim = 1'b1;
                end
            end
            n_time_below = r_clock_ms;
        end
        if (w_pass) begin
            w_action = ACT_RELEASE;
        end else if (w_trim) begin
            w_action = ACT_TRIM;
        end else begin
            w_action = ACT_HOLD;
        end
    end

    // Clock, gate state and peak statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_ms     <= '0;
            r_time_below   <= '0;
            r_time_above   <= '0;
            r_prev_level   <= '0;
            r_await_start  <= 1'b1;
            r_await_finish <= 1'b0;
            r_recording    <= 1'b0;
            r_top_peak     <= '0;
            r_bottom_peak  <= RST_MAX_AMPLITUDE;
        end else begin
            if (i_cmd.advance) begin
                r_clock_ms <= r_clock_ms + CLOCK_W'(w_quo);
            end
            if (i_cmd.gate) begin
                if (r_run_peak > r_top_peak) begin
                    r_top_peak <= r_run_peak;
                end
                if (r_run_peak < r_bottom_peak) begin
                    r_bottom_peak <= r_run_peak;
                end
                if (r_detect_enable) begin
                    r_await_start  <= n_await_start;
                    r_await_finish <= n_await_finish;
                    r_recording    <= n_recording;
                    r_time_below   <= n_time_below;
                    r_time_above   <= n_time_above;
                    r_prev_level   <= r_run_peak;
                end
            end
        end
    end

    // Per-chunk gate results
    always_ff @(posedge i_clk) begin
        if (i_cmd.gate) begin
            r_res_clip <= w_clip;
            if (r_detect_enable) begin
                r_res_action <= w_action;
                r_res_listen <= w_listen;
                r_res_done   <= w_done;
            end else begin
                r_res_action <= ACT_RAW;
                r_res_listen <= 1'b0;
                r_res_done   <= 1'b0;
            end
        end
    end

    // Output register: valid holds until the sink takes the word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_peak   <= r_run_peak;
            r_out_mean   <= r_mean;
            r_out_clip   <= r_res_clip;
            r_out_high   <= r_top_peak;
            r_out_low    <= r_bottom_peak;
            r_out_action <= r_res_action;
            r_out_listen <= r_res_listen;
            r_out_done   <= r_res_done;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.chunk_peak    = r_out_peak;
    assign o_out.chunk_mean    = r_out_mean;
    assign o_out.clipped       = r_out_clip;
    assign o_out.highest_peak  = r_out_high;
    assign o_out.lowest_peak   = r_out_low;
    assign o_out.buffer_action = r_out_action;
    assign o_out.listening     = r_out_listen;
    assign o_out.complete      = r_out_done;

    // Status to the controller
    assign o_status.last          = r_chunk_end || (w_count_inc == CNT_W'(MAX_CHUNK_SAMPLES));
    assign o_status.div_done      = w_div_done;
    assign o_status.detect_enable = r_detect_enable;
    assign o_status.out_free      = !r_out_valid || o_out.ready;

endmodule

`default_nettype wire

[rtl/voice_activity_gate.sv]
// Voice activity gate top level: controller plus datapath.
// Samples enter on i_in (valid/ready), one word per chunk result leaves on
// o_out, registers are written through i_cfg (always ready, index 0..6).
// Sample handling:
//   - a sample that does not end a chunk is captured, then accumulated;
//   - a chunk-ending sample also runs the shared one-bit-per-cycle divider,
//     SUM_W = 16 + clog2(MAX_CHUNK_SAMPLES + 1) steps per division: once for
//     the mean, and once more for the millisecond clock when detection is on.
//     The gate then runs and the result is registered in the output register.
//   - one sample is in work at a time; the divider sets the chunk-end cost.
// A chunk closes on chunk_end or when it reaches MAX_CHUNK_SAMPLES samples.
// Reset (synchronous, active low) loads register defaults, clears the
// accumulators and statistics, and arms the gate to wait for a start.
// Output stall: the result word sits in the output register until taken;
// samples that do not end a chunk keep being accepted meanwhile, and the
// next chunk end waits until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module voice_activity_gate import vag_pkg::*; #(
    parameter int MAX_CHUNK_SAMPLES = MAX_CHUNK_SAMPLES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    vag_in_if.sink    i_in,
    vag_out_if.source o_out,
    vag_cfg_if.sink   i_cfg
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    // Sequencer
    vag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Datapath
    vag_dp #(
        .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_sample    (i_in.sample),
        .i_chunk_end (i_in.chunk_end),
        .i_cfg       (i_cfg),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
